// ----- hw/rtl/btk_pkg.sv -----
// Package: constants, types and command codes for the bounded top-k heap.
`default_nettype none
package btk_pkg;
    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 32;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_OFFER = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b1;
endpackage
`default_nettype wire

// ----- hw/rtl/btk_ram.sv -----
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module btk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/bounded_top_k_heap.sv -----
// Top level: bounded binary heap keeping the best K keyed items of a stream.
// Steps: read, clear and no-op pass through the read, compare and done states; an offer
// below capacity reads and compares the parent per level moved up, then writes the item;
// an offer at capacity compares with the root, then reads both children and picks per level.
// Transfers are taken only in idle, reached once the result is loaded; a waiting result
// holds only the final step. Reset clears count and mode, sets capacity to DEPTH (max 64).
`default_nettype none
module bounded_top_k_heap #(
    parameter int DEPTH    = btk_pkg::DEPTH_DEF,
    parameter int KEY_BITS = btk_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = btk_pkg::TAG_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cfg_we,
    input  wire logic [btk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [btk_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // cmd[1:0], key, tag, slot[5:0], zero fill to whole bytes
    input  wire logic [((2+KEY_BITS+TAG_BITS+6+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // accepted, count[6:0], slot_valid, out_key, out_tag, zero fill
    output logic [((9+KEY_BITS+TAG_BITS+7)/8)*8-1:0] m_tdata
);
    import btk_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = 9 + KEY_BITS + TAG_BITS;
    localparam int SOW = ((OW + 7) / 8) * 8;
    localparam int DW = KEY_BITS + TAG_BITS;
    localparam int CW = AW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_LRD   = 7'b0001000,
        S_RRD   = 7'b0010000,
        S_PICK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic          mode_reg;
    logic [6:0]    cap_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_t          cmd_reg;
    logic [5:0]    slot_reg;
    logic [DW-1:0] item_reg;         // travelling item {key, tag}
    logic [AW-1:0] pos_reg, pos_next;
    logic [DW-1:0] left_reg;
    logic          up_reg;           // 1 sift up, 0 sift down
    logic          acc_reg;
    logic          root_reg;         // first read of replace path
    logic          out_v_reg;
    logic [OW-1:0] out_reg;

    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] wdata, rdata;

    btk_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    function automatic logic before_f(input logic m, input logic [KEY_BITS-1:0] a,
                                      input logic [KEY_BITS-1:0] b);
        logic signed [KEY_BITS-1:0] x, y;
        x = a; y = b;
        return m ? (x > y) : (x < y);
    endfunction

    logic [CW-1:0] cap_eff;
    always_comb begin
        if (cap_reg == 7'd0) cap_eff = CW'(1);
        else if (32'(cap_reg) > DEPTH) cap_eff = CW'(DEPTH);
        else cap_eff = CW'(cap_reg);
    end

    wire in_acc = s_tvalid && s_tready;
    cmd_t in_cmd;
    assign in_cmd = cmd_t'(s_tdata[1:0]);
    wire below_cap = cnt_reg < cap_eff;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = SOW'(out_reg);

    wire [KEY_BITS-1:0] ikey = item_reg[DW-1:TAG_BITS];
    wire [KEY_BITS-1:0] rkey = rdata[DW-1:TAG_BITS];
    wire [KEY_BITS-1:0] lkey = left_reg[DW-1:TAG_BITS];
    wire [AW:0] lidx = {pos_reg, 1'b1};
    wire [AW:0] ridx = {pos_reg, 1'b0} + (AW+1)'(2);
    wire l_in = (CW+1)'(lidx) < (CW+1)'(cnt_reg);
    wire r_in = (CW+1)'(ridx) < (CW+1)'(cnt_reg);
    wire [AW-1:0] parent = AW'((pos_reg - AW'(1)) >> 1);
    wire root_hit = (state_reg == S_CMP) && cmd_reg == CMD_OFFER && !up_reg && root_reg &&
                    before_f(mode_reg, rkey, ikey);
    wire out_load = (state_reg == S_DONE) && (!out_v_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        we = 1'b0;
        addr = (cmd_reg == CMD_READ) ? AW'(slot_reg) : pos_reg;
        wdata = item_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_RD;
                    if (in_cmd == CMD_OFFER && below_cap) begin
                        pos_next = AW'(cnt_reg);
                        cnt_next = cnt_reg + CW'(1);
                    end else begin
                        pos_next = '0;
                    end
                    if (in_cmd == CMD_CLEAR) cnt_next = '0;
                end
            end
            S_RD: begin
                // issue read of slot, parent, or root
                case (cmd_reg)
                    CMD_READ:  addr = AW'(slot_reg);
                    CMD_OFFER: addr = up_reg ? parent : AW'(0);
                    default:   addr = pos_reg;
                endcase
                if (cmd_reg == CMD_OFFER && up_reg && pos_reg == AW'(0)) begin
                    we = 1'b1;
                    addr = pos_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_DONE;
                if (cmd_reg == CMD_OFFER) begin
                    if (up_reg) begin
                        if (before_f(mode_reg, ikey, rkey)) begin
                            we = 1'b1; addr = pos_reg; wdata = rdata;
                            pos_next = parent;
                            state_next = S_RD;
                        end else begin
                            we = 1'b1;
                        end
                    end else if (root_reg) begin
                        if (!before_f(mode_reg, rkey, ikey)) state_next = S_DONE;
                        else begin
                            state_next = l_in ? S_LRD : S_DONE;
                            if (!l_in) begin we = 1'b1; addr = AW'(0); end
                        end
                    end else begin
                        // new position reached; read its children or finish
                        if (l_in) state_next = S_LRD;
                        else we = 1'b1;
                    end
                end
            end
            S_LRD: begin
                addr = AW'(lidx);
                state_next = S_RRD;
            end
            S_RRD: begin
                addr = AW'(ridx);
                state_next = S_PICK;
            end
            S_PICK: begin
                state_next = S_DONE;
                begin : pick
                    logic [DW-1:0] bst;
                    logic          moved, rbest;
                    bst = item_reg; moved = 1'b0; rbest = 1'b0;
                    if (before_f(mode_reg, lkey, ikey)) begin bst = left_reg; moved = 1'b1; end
                    if (r_in && before_f(mode_reg, rkey, bst[DW-1:TAG_BITS])) begin
                        bst = rdata; moved = 1'b1; rbest = 1'b1;
                    end
                    we = 1'b1;
                    addr = pos_reg;
                    wdata = moved ? bst : item_reg;
                    if (moved) begin
                        pos_next = rbest ? AW'(ridx) : AW'(lidx);
                        state_next = S_CMP;
                    end
                end
            end
            S_DONE: state_next = out_load ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= 1'b0;
            cap_reg   <= 7'(DEPTH > 64 ? 64 : DEPTH);
            cnt_reg   <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_KEEP_MODE) mode_reg <= cfg_data[0];
                else cap_reg <= cfg_data;
            end
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
            if (in_acc) begin
                cmd_reg  <= in_cmd;
                item_reg <= {s_tdata[2 +: KEY_BITS], s_tdata[2+KEY_BITS +: TAG_BITS]};
                slot_reg <= s_tdata[2+DW +: 6];
                up_reg   <= (in_cmd == CMD_OFFER) && below_cap;
                acc_reg  <= (in_cmd == CMD_OFFER) && below_cap;
                root_reg <= 1'b1;
            end
            if (root_hit) begin
                acc_reg <= 1'b1;
                root_reg <= 1'b0;
            end
            if (state_reg == S_RRD) left_reg <= rdata;
            if (out_load) begin
                out_v_reg <= 1'b1;
                out_reg <= {(cmd_reg == CMD_READ && (CW+1)'(slot_reg) < (CW+1)'(cnt_reg)) ?
                                rdata[TAG_BITS-1:0] : TAG_BITS'(0),
                            (cmd_reg == CMD_READ && (CW+1)'(slot_reg) < (CW+1)'(cnt_reg)) ?
                                rdata[DW-1:TAG_BITS] : KEY_BITS'(0),
                            cmd_reg == CMD_READ && (CW+1)'(slot_reg) < (CW+1)'(cnt_reg),
                            7'(cnt_reg), acc_reg};
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH)) else $error("count above depth");
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> m_tvalid) else $error("result lost");
`endif
endmodule
`default_nettype wire
